/* src/bmcc_pkg.sv */
// ----------------------------------------------------------------------------
// bmcc_pkg: shared types and constants for the button multi-click classifier
// Gesture codes, register indexes, reset values and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package bmcc_pkg;

  localparam int unsigned TickW  = 16;
  localparam int unsigned TallyW = 8;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [TickW-1:0]  TickMax       = '1;
  localparam logic [TallyW-1:0] TallyMax      = '1;
  localparam logic [TallyW-1:0] MultiClicks   = TallyW'(3);
  localparam logic [TallyW-1:0] DoubleClicks  = TallyW'(2);
  localparam logic [TallyW-1:0] SingleClicks  = TallyW'(1);

  localparam logic [TickW-1:0] LongPressRst   = TickW'(500);
  localparam logic [TickW-1:0] MinClickRst    = TickW'(50);
  localparam logic [TickW-1:0] ClickWindowRst = TickW'(300);

  typedef enum logic [2:0] {
    GEST_NONE   = 3'd0,
    GEST_LONG   = 3'd1,
    GEST_SINGLE = 3'd2,
    GEST_DOUBLE = 3'd3,
    GEST_MULTI  = 3'd4
  } gesture_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LONG_PRESS   = 2'd0,
    CFG_MIN_CLICK    = 2'd1,
    CFG_CLICK_WINDOW = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    OP_TICK   = 1'b0,
    OP_CHANGE = 1'b1
  } opcode_t;

  typedef struct packed {
    logic [TickW-1:0] long_press_ticks;
    logic [TickW-1:0] min_click_ticks;
    logic [TickW-1:0] click_window_ticks;
  } cfg_t;

  typedef struct packed {
    gesture_t          gesture;
    logic [TallyW-1:0] clicks_pending;
  } result_t;

endpackage

`default_nettype wire

/* src/bmcc_core.sv */
// ----------------------------------------------------------------------------
// bmcc_core: press/click state and single-pass classification
// Holds the button state and counters, computes the result of one item in
// combinational logic and updates the state when the item is transferred.
// ----------------------------------------------------------------------------
`default_nettype none

module bmcc_core
  import bmcc_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    item_en,
  input  wire logic    opcode,
  input  wire logic    level,
  input  wire cfg_t    cfg,
  output result_t      result
);

  logic              held_r, held_nxt;
  logic [TickW-1:0]  hold_r, hold_nxt;
  logic [TallyW-1:0] tally_r, tally_nxt;
  logic              armed_r, armed_nxt;
  logic [TickW-1:0]  win_r, win_nxt;
  gesture_t          gesture;
  logic [TickW-1:0]  win_inc;

  always_comb begin
    held_nxt  = held_r;
    hold_nxt  = hold_r;
    tally_nxt = tally_r;
    armed_nxt = armed_r;
    win_nxt   = win_r;
    gesture   = GEST_NONE;
    win_inc   = (win_r != TickMax) ? win_r + TickW'(1) : win_r;

    if (opcode_t'(opcode) == OP_TICK) begin
      if (held_r && hold_r != TickMax) begin
        hold_nxt = hold_r + TickW'(1);
      end
      if (armed_r) begin
        win_nxt = win_inc;
        // window expires on the incremented count
        if (win_inc >= cfg.click_window_ticks) begin
          if (tally_r >= MultiClicks) begin
            gesture = GEST_MULTI;
          end else if (tally_r == DoubleClicks) begin
            gesture = GEST_DOUBLE;
          end else if (tally_r == SingleClicks) begin
            gesture = GEST_SINGLE;
          end
          tally_nxt = '0;
          armed_nxt = 1'b0;
          win_nxt   = '0;
        end
      end
    end else if (!level) begin
      hold_nxt = '0;
      held_nxt = 1'b1;
    end else if (held_r) begin
      if (hold_r > cfg.long_press_ticks) begin
        gesture   = GEST_LONG;
        tally_nxt = '0;
        armed_nxt = 1'b0;
        win_nxt   = '0;
      end else if (hold_r > cfg.min_click_ticks) begin
        if (tally_r != TallyMax) begin
          tally_nxt = tally_r + TallyW'(1);
        end
        if (!armed_r) begin
          armed_nxt = 1'b1;
          win_nxt   = '0;
        end
      end
      held_nxt = 1'b0;
    end

    result.gesture        = gesture;
    result.clicks_pending = tally_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r  <= 1'b0;
      hold_r  <= '0;
      tally_r <= '0;
      armed_r <= 1'b0;
      win_r   <= '0;
    end else if (item_en) begin
      held_r  <= held_nxt;
      hold_r  <= hold_nxt;
      tally_r <= tally_nxt;
      armed_r <= armed_nxt;
      win_r   <= win_nxt;
    end
  end

endmodule

`default_nettype wire

/* src/button_multi_click_classifier.sv */
// ----------------------------------------------------------------------------
// button_multi_click_classifier: long-press and multi-click detector
// Top level: configuration registers, classifier core and output skid stage.
// ----------------------------------------------------------------------------
// Each input item (a tick or a pin level change) is classified in
// combinational logic and gives exactly one result: the gesture it
// completes and the clicks pending in the open window. One item is taken
// per cycle while in_stall is low; the result is registered, and a second
// register absorbs one result while the output is stalled, so in_stall
// rises only once both are full. Configuration writes are always ready.
`default_nettype none

module button_multi_click_classifier
  import bmcc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output      logic               in_stall,
  input  wire logic               in_opcode,
  input  wire logic               in_level,
  output      logic               out_valid,
  input  wire logic               out_stall,
  output      logic [2:0]         out_gesture,
  output      logic [TallyW-1:0]  out_clicks_pending,
  input  wire logic               cfg_valid,
  output      logic               cfg_ready,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [TickW-1:0]   cfg_data
);

  cfg_t    cfg_r;
  result_t core_res;
  result_t out_r, skid_r;
  logic    out_valid_r, skid_valid_r;
  logic    in_xfer, out_xfer;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid_r;
  assign in_xfer   = in_valid && !skid_valid_r;
  assign out_xfer  = out_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.long_press_ticks   <= LongPressRst;
      cfg_r.min_click_ticks    <= MinClickRst;
      cfg_r.click_window_ticks <= ClickWindowRst;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_LONG_PRESS:   cfg_r.long_press_ticks   <= cfg_data;
        CFG_MIN_CLICK:    cfg_r.min_click_ticks    <= cfg_data;
        CFG_CLICK_WINDOW: cfg_r.click_window_ticks <= cfg_data;
        default:          ;
      endcase
    end
  end

  bmcc_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .item_en (in_xfer),
    .opcode  (in_opcode),
    .level   (in_level),
    .cfg     (cfg_r),
    .result  (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      // drain the skid entry; input is stalled meanwhile
      if (out_xfer) begin
        out_r        <= skid_r;
        skid_valid_r <= 1'b0;
      end
    end else if (in_xfer) begin
      if (!out_valid_r || out_xfer) begin
        out_r       <= core_res;
        out_valid_r <= 1'b1;
      end else begin
        skid_r       <= core_res;
        skid_valid_r <= 1'b1;
      end
    end else if (out_xfer) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_gesture        = out_r.gesture;
  assign out_clicks_pending = out_r.clicks_pending;

endmodule

`default_nettype wire

/* src/bmcc_checker.sv */
// ----------------------------------------------------------------------------
// bmcc_checker: port-level checks for the click classifier
// Watches the result channel for gesture sanity and stall behavior.
// ----------------------------------------------------------------------------
`default_nettype none

module bmcc_checker
  import bmcc_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic [2:0]         out_gesture,
  input wire logic [TallyW-1:0]  out_clicks_pending
);

  // any closing gesture leaves the window empty
  a_gesture_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_gesture != GEST_NONE) |-> (out_clicks_pending == '0))
    else $error("gesture reported with clicks still pending");

  a_gesture_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_gesture <= GEST_MULTI))
    else $error("gesture code out of range");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_gesture)
      && $stable(out_clicks_pending)))
    else $error("stalled result changed");

  // input stalls only with a result already waiting
  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with output empty");

  // a transfer into an empty output shows up on the next cycle
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && !out_valid) |=> out_valid)
    else $error("result missing after input transfer");

endmodule

bind button_multi_click_classifier bmcc_checker u_bmcc_checker (.*);

`default_nettype wire

/* tb/sv/button_multi_click_classifier_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_multi_click_classifier_tb: gesture classification check
// Drives ticks and pin changes through the classifier and checks each result
// against a cycle-free model of the press/click/window state. Directed cases
// cover reset settings, thresholds, windows and saturation; random traffic
// runs under several register settings and idle/stall mixes.
// ----------------------------------------------------------------------------

module button_multi_click_classifier_tb
  import bmcc_pkg::*;
();

  localparam int StallLimit = 2000;
  localparam logic LvlPressed  = 1'b0;
  localparam logic LvlReleased = 1'b1;
  localparam logic [CfgIdxW-1:0] CfgUnmapped = 2'd3;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_opcode = 1'b0;
  logic in_level = 1'b1;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] out_gesture;
  logic [TallyW-1:0] out_clicks_pending;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [TickW-1:0] cfg_data = '0;

  // Model of the classifier state and its registers
  cfg_t model_cfg = '{LongPressRst, MinClickRst, ClickWindowRst};
  logic btn_held = 1'b0;
  logic [TickW-1:0] hold_ticks = '0;
  logic [TallyW-1:0] model_tally = '0;
  logic win_open = 1'b0;
  logic [TickW-1:0] win_ticks = '0;

  result_t pending_gestures[$];
  int mismatches = 0;
  int items_sent = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;

  button_multi_click_classifier dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_opcode          (in_opcode),
    .in_level           (in_level),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_gesture        (out_gesture),
    .out_clicks_pending (out_clicks_pending),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic result_t classify_event(opcode_t op, logic lvl);
    result_t r;
    r.gesture = GEST_NONE;
    if (op == OP_TICK) begin
      if (btn_held && hold_ticks != TickMax) hold_ticks++;
      if (win_open) begin
        if (win_ticks != TickMax) win_ticks++;
        if (win_ticks >= model_cfg.click_window_ticks) begin
          if (model_tally >= MultiClicks) r.gesture = GEST_MULTI;
          else if (model_tally == DoubleClicks) r.gesture = GEST_DOUBLE;
          else if (model_tally == SingleClicks) r.gesture = GEST_SINGLE;
          model_tally = '0;
          win_open = 1'b0;
          win_ticks = '0;
        end
      end
    end else if (lvl == LvlPressed) begin
      // a press while held restarts the hold
      hold_ticks = '0;
      btn_held = 1'b1;
    end else if (btn_held) begin
      if (hold_ticks > model_cfg.long_press_ticks) begin
        r.gesture = GEST_LONG;
        model_tally = '0;
        win_open = 1'b0;
        win_ticks = '0;
      end else if (hold_ticks > model_cfg.min_click_ticks) begin
        if (model_tally != TallyMax) model_tally++;
        if (!win_open) begin
          win_open = 1'b1;
          win_ticks = '0;
        end
      end
      btn_held = 1'b0;
    end
    r.clicks_pending = model_tally;
    return r;
  endfunction

  task automatic report_mismatch(string field, int unsigned got, int unsigned want);
    $display("%0t ns: %s got %0d, want %0d", $time, field, got, want);
    mismatches++;
  endtask

  // Receiver: random stall, check every transfer against the oldest prediction
  always @(posedge clk) begin
    result_t want;
    out_stall <= ($urandom_range(99) < recv_stall_pct);
    if (rst_n && out_valid && !out_stall) begin
      if (pending_gestures.size() == 0) begin
        report_mismatch("unexpected result, gesture", out_gesture, GEST_NONE);
      end else begin
        want = pending_gestures.pop_front();
        if (out_gesture !== want.gesture)
          report_mismatch("gesture", out_gesture, want.gesture);
        if (out_clicks_pending !== want.clicks_pending)
          report_mismatch("clicks_pending", out_clicks_pending, want.clicks_pending);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= StallLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic set_idling(int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  task automatic send_event(opcode_t op, logic lvl);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_opcode <= op;
    in_level  <= lvl;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_gestures.push_back(classify_event(op, lvl));
    items_sent++;
  endtask

  task automatic send_ticks(int n);
    repeat (n) send_event(OP_TICK, 1'($urandom_range(1)));
  endtask

  task automatic press_hold(int n);
    send_event(OP_CHANGE, LvlPressed);
    send_ticks(n);
    send_event(OP_CHANGE, LvlReleased);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_gestures.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Leaves cfg_valid high; the caller drops it after its last write
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [TickW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_LONG_PRESS:   model_cfg.long_press_ticks = val;
      CFG_MIN_CLICK:    model_cfg.min_click_ticks = val;
      CFG_CLICK_WINDOW: model_cfg.click_window_ticks = val;
      default: ;
    endcase
  endtask

  task automatic apply_config(int long_t, int min_t, int win_t);
    wait_drained();
    write_reg(CFG_LONG_PRESS, TickW'(long_t));
    write_reg(CFG_MIN_CLICK, TickW'(min_t));
    write_reg(CFG_CLICK_WINDOW, TickW'(win_t));
    cfg_valid <= 1'b0;
  endtask

  function automatic int pick_near(int bound, int cap);
    int v;
    case ($urandom_range(3))
      0: v = bound;
      1: v = bound + 1;
      2: v = (bound > 0) ? bound - 1 : 0;
      default: v = $urandom_range(bound + 1);
    endcase
    if (v > cap) v = $urandom_range(cap);
    return v;
  endfunction

  task automatic test_reset_config();
    press_hold(50);  // exactly the click threshold: no click
    press_hold(51);
    send_ticks(300);
  endtask

  task automatic test_click_gestures();
    wait_drained();
    write_reg(CfgUnmapped, '1);  // unmapped index: must change nothing
    cfg_valid <= 1'b0;
    apply_config(10, 2, 8);
    send_event(OP_CHANGE, LvlReleased);  // release while not held
    send_ticks(2);
    press_hold(2);
    press_hold(3);
    send_ticks(8);
    press_hold(3);
    send_ticks(1);
    press_hold(3);
    send_ticks(8);
    repeat (3) press_hold(3);
    send_ticks(8);
    press_hold(11);
    press_hold(10);
    send_ticks(8);
    apply_config(4, 1, 20);
    press_hold(2);
    press_hold(5);  // long press drops the pending click
    send_ticks(20);
    send_event(OP_CHANGE, LvlPressed);
    send_ticks(3);
    repeat (5) press_hold(2);
    send_ticks(20);
  endtask

  task automatic test_zero_window();
    apply_config(4, 1, 0);
    press_hold(2);
    send_ticks(2);
  endtask

  task automatic test_tally_saturation();
    apply_config(2, 0, 1000);
    repeat (257) press_hold(1);
    press_hold(3);
    send_ticks(2);
  endtask

  // top thresholds: no hold ever qualifies as a click or a long press
  task automatic test_max_thresholds();
    apply_config(TickMax, TickMax, 1);
    set_idling(0, 0);
    press_hold(40);
    press_hold(1);
    send_ticks(2);
    set_idling(17, 17);
  endtask

  task automatic run_random(int n_items);
    int stop_at;
    int hold;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      if ($urandom_range(99) < 80) begin
        repeat ($urandom_range(1, 5)) begin
          if ($urandom_range(1)) hold = pick_near(model_cfg.min_click_ticks, 40);
          else hold = pick_near(model_cfg.long_press_ticks, 40);
          press_hold(hold);
          send_ticks($urandom_range(0, 3));
        end
        send_ticks(pick_near(model_cfg.click_window_ticks, 60));
      end else begin
        send_event(opcode_t'($urandom_range(1)), 1'($urandom_range(1)));
      end
    end
  endtask

  task automatic test_random_traffic();
    int long_t;
    long_t = $urandom_range(6, 40);
    set_idling(0, 0);
    apply_config(long_t, $urandom_range(0, long_t), $urandom_range(1, 30));
    run_random(25);
    set_idling(64, 0);
    apply_config(0, 0, 1);
    run_random(25);
    set_idling(0, 64);
    apply_config(TickMax, 5, TickMax);
    run_random(25);
    set_idling(17, 17);
    long_t = $urandom_range(6, 40);
    apply_config(long_t, $urandom_range(0, long_t), $urandom_range(1, 30));
    run_random(25);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_idling(17, 17);
    test_reset_config();
    test_click_gestures();
    test_zero_window();
    test_tally_saturation();
    test_max_thresholds();
    test_random_traffic();
    wait_drained();
    if (mismatches == 0 && pending_gestures.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
